@@ hw/rtl/lpht_pkg.sv @@
// Package for the linear probe hash table: sizes, payload structs, codes and states.
package lpht_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 65536;
   localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
   localparam int OCC_BITS    = ADDR_BITS + 1;
   localparam int INDEX_BITS  = 24;
   localparam int FLAVOR_BITS = 6;
   localparam int KEY_BITS    = 5 * FLAVOR_BITS;
   localparam int MIX_BITS    = 32;

   // Mixer multiplier and load limit (occupancy at which inserts are refused)
   localparam logic [MIX_BITS-1:0] MIX_MULT   = 32'h045d_9f3b;
   localparam logic [OCC_BITS-1:0] LOAD_LIMIT = OCC_BITS'(3 * TABLE_DEPTH / 4);

   typedef enum logic [1:0] {
      MODE_LOOKUP = 2'd0,
      MODE_CLOSE  = 2'd1,
      MODE_REOPEN = 2'd2,
      MODE_INSERT = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef struct packed {
      mode_type               mode;
      logic [FLAVOR_BITS-1:0] flavor_0;
      logic [FLAVOR_BITS-1:0] flavor_1;
      logic [FLAVOR_BITS-1:0] flavor_2;
      logic [FLAVOR_BITS-1:0] flavor_3;
      logic [FLAVOR_BITS-1:0] flavor_4;
      logic [INDEX_BITS-1:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic                  found;
      logic                  was_closed;
      logic [INDEX_BITS-1:0] stored_index;
      status_type            status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_XS,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;

endpackage

@@ hw/rtl/linear_probe_hash_table.sv @@
// Top level: open addressing hash table with linear probing and a shared mixer multiplier.
//
//   Channel   Ports                          Moves
//   request   req_valid req_ready req_data   mode, five key parts, entry index
//   response  rsp_valid rsp_ready rsp_data   found, closed mark, index, status
//
// A request's result reaches the output register through the hash steps (MUL then XS,
// done twice), one READ then CHECK per slot probed, and DONE; the hash uses one 32x32
// multiplier twice, and each probe is one read of the slot memories. A new request is
// taken only once the previous one has left DONE for the output register.
// An all-zero key skips hashing and probing: it goes from IDLE straight to DONE, and
// the next request can follow once its result has been registered.
// After reset a clearing pass over all TABLE_DEPTH slots (65536) empties the key and
// closed-mark memories; req_ready stays low during it.
// A result waiting in the output register holds the sequencer in its last step.
module linear_probe_hash_table
   import lpht_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Slot memories
   logic [KEY_BITS-1:0]   key_mem    [TABLE_DEPTH];
   logic                  closed_mem [TABLE_DEPTH];
   logic [INDEX_BITS-1:0] index_mem  [TABLE_DEPTH];

   state_type             state_ff, state_in;
   req_type               req_ff, req_in;
   logic [MIX_BITS-1:0]   mix_ff, mix_in;
   logic                  round_ff, round_in;
   logic [ADDR_BITS-1:0]  pos_ff, pos_in;
   logic [ADDR_BITS-1:0]  clr_addr_ff, clr_addr_in;
   logic [OCC_BITS-1:0]   occ_ff, occ_in;
   rsp_type               res_ff, res_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KEY_BITS-1:0]   rd_key_ff;
   logic                  rd_closed_ff;
   logic [INDEX_BITS-1:0] rd_index_ff;

   logic                  rd_en;
   logic                  key_we, closed_we, index_we;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [KEY_BITS-1:0]   key_wdata;
   logic                  closed_wdata;
   logic                  out_free;
   logic [KEY_BITS-1:0]   req_key, cur_key;
   logic [MIX_BITS-1:0]   req_key_wide, mix_prod, mix_xs;
   logic                  slot_empty, slot_hit;

   assign req_key = {req_data.flavor_4, req_data.flavor_3, req_data.flavor_2,
                     req_data.flavor_1, req_data.flavor_0};
   assign cur_key = {req_ff.flavor_4, req_ff.flavor_3, req_ff.flavor_2,
                     req_ff.flavor_1, req_ff.flavor_0};
   assign req_key_wide = MIX_BITS'(req_key);

   // Shared mixer unit: one multiply or one xor-shift per cycle
   assign mix_prod = mix_ff * MIX_MULT;
   assign mix_xs   = mix_ff ^ (mix_ff >> 16);

   assign slot_empty = (rd_key_ff == '0);
   assign slot_hit   = (rd_key_ff == cur_key);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == ADDR_BITS'(TABLE_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = (req_key == '0) ? ST_DONE : ST_MUL;
         end
         ST_MUL:   state_in = ST_XS;
         ST_XS:    state_in = round_ff ? ST_READ : ST_MUL;
         ST_READ:  state_in = ST_CHECK;
         ST_CHECK: state_in = (slot_empty || slot_hit) ? ST_DONE : ST_READ;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_CLEAR;
      endcase
   end

   // Outputs and datapath control
   always_comb begin
      req_ready    = 1'b0;
      req_in       = req_ff;
      mix_in       = mix_ff;
      round_in     = round_ff;
      pos_in       = pos_ff;
      clr_addr_in  = clr_addr_ff;
      occ_in       = occ_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_en        = 1'b0;
      key_we       = 1'b0;
      closed_we    = 1'b0;
      index_we     = 1'b0;
      wr_addr      = pos_ff;
      key_wdata    = cur_key;
      closed_wdata = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_addr     = clr_addr_ff;
            key_wdata   = '0;
            key_we      = 1'b1;
            closed_we   = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_data;
               mix_in   = req_key_wide ^ (req_key_wide >> 16);
               round_in = 1'b0;
               // All-zero key is the empty marker: never present
               res_in   = '{found: 1'b0, was_closed: 1'b0, stored_index: '0,
                            status: (req_data.mode == MODE_INSERT) ? STATUS_FULL
                                                                   : STATUS_MISS};
            end
         end
         ST_MUL: begin
            mix_in = mix_prod;
         end
         ST_XS: begin
            mix_in   = mix_xs;
            round_in = 1'b1;
            pos_in   = mix_xs[ADDR_BITS-1:0];
         end
         ST_READ: begin
            rd_en = 1'b1;
         end
         ST_CHECK: begin
            if (slot_empty) begin
               res_in = '{found: 1'b0, was_closed: 1'b0, stored_index: '0,
                          status: STATUS_MISS};
               if (req_ff.mode == MODE_INSERT) begin
                  if (occ_ff >= LOAD_LIMIT) begin
                     res_in.status = STATUS_FULL;
                  end else begin
                     res_in.status = STATUS_DONE;
                     key_we        = 1'b1;
                     closed_we     = 1'b1;
                     index_we      = 1'b1;
                     occ_in        = occ_ff + 1'b1;
                  end
               end
            end else if (slot_hit) begin
               res_in = '{found: 1'b1, was_closed: rd_closed_ff,
                          stored_index: rd_index_ff, status: STATUS_DONE};
               if (req_ff.mode == MODE_CLOSE) begin
                  closed_we    = 1'b1;
                  closed_wdata = 1'b1;
               end else if (req_ff.mode == MODE_REOPEN) begin
                  closed_we = 1'b1;
               end
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         occ_ff       <= '0;
         round_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         occ_ff       <= occ_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      mix_ff <= mix_in;
      pos_ff <= pos_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   // Memory writes
   always_ff @(posedge clock) begin
      if (key_we) key_mem[wr_addr] <= key_wdata;
      if (closed_we) closed_mem[wr_addr] <= closed_wdata;
      if (index_we) index_mem[wr_addr] <= req_ff.entry_index;
   end

   // Registered memory reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff    <= key_mem[pos_ff];
         rd_closed_ff <= closed_mem[pos_ff];
         rd_index_ff  <= index_mem[pos_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hw/rtl/lpht_checker.sv @@
// Port-level checker for the linear probe hash table, with its bind.
module lpht_checker
   import lpht_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // The sequencer is busy right after it takes a request
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // A refused or missing key reports nothing from the table
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_FULL || rsp_data.status == STATUS_MISS)
      |-> !rsp_data.found && !rsp_data.was_closed && rsp_data.stored_index == '0)
      else $error("miss or refusal carries table data");

   // A hit always completes
   a_found_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.status == STATUS_DONE)
      else $error("hit with non-done status");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

@@ test/tb_linear_probe_hash_table.sv @@
// Testbench for the linear probe hash table: directed table and random traffic.
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;
   import lpht_pkg::*;

   localparam int RESET_CYCLES   = 9;
   localparam int RANDOM_ITEMS   = 2000;
   localparam int POOL_MAX       = 512;
   localparam int MAX_REPORTS    = 10;
   localparam int DRAIN_CYCLES   = 20;
   // longest quiet stretch is the clearing pass after reset
   localparam int WATCHDOG_LIMIT = 300000;

   localparam logic [KEY_BITS-1:0] KEY_ZERO = 30'h0000_0000;
   localparam logic [KEY_BITS-1:0] KEY_LOW  = 30'h0000_0001;
   localparam logic [KEY_BITS-1:0] KEY_HIGH = 30'h3FFF_FFFF;
   localparam logic [KEY_BITS-1:0] KEY_ONES = 30'h0104_1041;
   localparam logic [KEY_BITS-1:0] KEY_TOP  = 30'h2000_0000;

   // one row of the directed table; want is used only when typed is set
   typedef struct packed {
      mode_type              mode;
      logic [KEY_BITS-1:0]   key;
      logic [INDEX_BITS-1:0] index;
      logic                  typed;
      rsp_type               want;
   } step_row_type;

   localparam int DIRECTED_COUNT = 23;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // shadow of the table contents
   logic [KEY_BITS-1:0]   shadow_keys   [TABLE_DEPTH];
   logic [INDEX_BITS-1:0] shadow_index  [TABLE_DEPTH];
   logic                  shadow_closed [TABLE_DEPTH];
   int                    shadow_fill;

   rsp_type             expected_results [$];
   logic [KEY_BITS-1:0] key_pool [$];
   bit                  no_idle = 1'b0;
   int                  mismatch_count = 0;
   int                  rsp_stall = 0;

   step_row_type directed_steps [DIRECTED_COUNT] = '{
      // empty table, all-zero key
      {MODE_LOOKUP, KEY_LOW,  24'h000000, 1'b1, 1'b0, 1'b0, 24'h000000, STATUS_MISS},
      {MODE_LOOKUP, KEY_ZERO, 24'h000000, 1'b1, 1'b0, 1'b0, 24'h000000, STATUS_MISS},
      {MODE_INSERT, KEY_ZERO, 24'hFFFFFF, 1'b1, 1'b0, 1'b0, 24'h000000, STATUS_FULL},
      {MODE_CLOSE,  KEY_ZERO, 24'h000000, 1'b1, 1'b0, 1'b0, 24'h000000, STATUS_MISS},
      {MODE_REOPEN, KEY_ZERO, 24'h000000, 1'b1, 1'b0, 1'b0, 24'h000000, STATUS_MISS},
      // fresh inserts
      {MODE_INSERT, KEY_LOW,  24'hFFFFFF, 1'b1, 1'b0, 1'b0, 24'h000000, STATUS_DONE},
      {MODE_INSERT, KEY_HIGH, 24'h000000, 1'b1, 1'b0, 1'b0, 24'h000000, STATUS_DONE},
      {MODE_INSERT, KEY_ONES, 24'h01E240, 1'b1, 1'b0, 1'b0, 24'h000000, STATUS_DONE},
      // close and reopen sequence
      {MODE_LOOKUP, KEY_LOW,  24'h000000, 1'b1, 1'b1, 1'b0, 24'hFFFFFF, STATUS_DONE},
      {MODE_CLOSE,  KEY_LOW,  24'h000000, 1'b1, 1'b1, 1'b0, 24'hFFFFFF, STATUS_DONE},
      {MODE_CLOSE,  KEY_LOW,  24'h000000, 1'b1, 1'b1, 1'b1, 24'hFFFFFF, STATUS_DONE},
      {MODE_LOOKUP, KEY_LOW,  24'h000000, 1'b1, 1'b1, 1'b1, 24'hFFFFFF, STATUS_DONE},
      {MODE_INSERT, KEY_LOW,  24'h000005, 1'b1, 1'b1, 1'b1, 24'hFFFFFF, STATUS_DONE},
      {MODE_REOPEN, KEY_LOW,  24'h000000, 1'b1, 1'b1, 1'b1, 24'hFFFFFF, STATUS_DONE},
      {MODE_REOPEN, KEY_LOW,  24'h000000, 1'b1, 1'b1, 1'b0, 24'hFFFFFF, STATUS_DONE},
      {MODE_LOOKUP, KEY_HIGH, 24'h000000, 1'b1, 1'b1, 1'b0, 24'h000000, STATUS_DONE},
      // misses change nothing, then the missing key is inserted
      {MODE_CLOSE,  KEY_TOP,  24'h000000, 1'b1, 1'b0, 1'b0, 24'h000000, STATUS_MISS},
      {MODE_REOPEN, KEY_TOP,  24'h000000, 1'b1, 1'b0, 1'b0, 24'h000000, STATUS_MISS},
      {MODE_LOOKUP, KEY_TOP,  24'h000000, 1'b1, 1'b0, 1'b0, 24'h000000, STATUS_MISS},
      {MODE_INSERT, KEY_TOP,  24'h800000, 1'b1, 1'b0, 1'b0, 24'h000000, STATUS_DONE},
      // predicted rows
      {MODE_CLOSE,  KEY_ONES, 24'h000000, 1'b0, 1'b0, 1'b0, 24'h000000, STATUS_DONE},
      {MODE_LOOKUP, KEY_ONES, 24'h000000, 1'b0, 1'b0, 1'b0, 24'h000000, STATUS_DONE},
      {MODE_INSERT, KEY_HIGH, 24'hFFFFFF, 1'b0, 1'b0, 1'b0, 24'h000000, STATUS_DONE}
   };

   linear_probe_hash_table DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // xor-shift / multiply key mixer
   function automatic logic [MIX_BITS-1:0] mix_key(input logic [MIX_BITS-1:0] v);
      v = v ^ (v >> 16);
      v = v * MIX_MULT;
      v = v ^ (v >> 16);
      v = v * MIX_MULT;
      v = v ^ (v >> 16);
      return v;
   endfunction

   // apply one request to the shadow table and return its response
   function automatic rsp_type table_update(input req_type r);
      logic [KEY_BITS-1:0]  key;
      logic [MIX_BITS-1:0]  hash;
      logic [ADDR_BITS-1:0] pos;
      logic                 hit;
      logic                 has_empty;
      int                   n;
      rsp_type              res;
      key = {r.flavor_4, r.flavor_3, r.flavor_2, r.flavor_1, r.flavor_0};
      res = '0;
      res.status = STATUS_DONE;
      hit = 1'b0;
      has_empty = 1'b0;
      pos = '0;
      n = 0;
      if (key != '0) begin
         hash = mix_key({2'b00, key});
         pos = hash[ADDR_BITS-1:0];
         // linear probe, wrapping through the address width
         while (!hit && !has_empty && n < TABLE_DEPTH) begin
            if (shadow_keys[pos] == '0) begin
               has_empty = 1'b1;
            end else if (shadow_keys[pos] == key) begin
               hit = 1'b1;
            end else begin
               pos = pos + 1'b1;
               n++;
            end
         end
      end
      if (hit) begin
         res.found = 1'b1;
         res.was_closed = shadow_closed[pos];
         res.stored_index = shadow_index[pos];
         if (r.mode == MODE_CLOSE) begin
            shadow_closed[pos] = 1'b1;
         end else if (r.mode == MODE_REOPEN) begin
            shadow_closed[pos] = 1'b0;
         end
      end else if (r.mode == MODE_INSERT) begin
         if (key == '0 || !has_empty || shadow_fill >= LOAD_LIMIT) begin
            res.status = STATUS_FULL;
         end else begin
            shadow_keys[pos] = key;
            shadow_index[pos] = r.entry_index;
            shadow_closed[pos] = 1'b0;
            shadow_fill++;
         end
      end else begin
         res.status = STATUS_MISS;
      end
      return res;
   endfunction

   function automatic req_type build_req(input mode_type m, input logic [KEY_BITS-1:0] k,
                                         input logic [INDEX_BITS-1:0] idx);
      req_type r;
      r.mode = m;
      r.flavor_0 = k[5:0];
      r.flavor_1 = k[11:6];
      r.flavor_2 = k[17:12];
      r.flavor_3 = k[23:18];
      r.flavor_4 = k[29:24];
      r.entry_index = idx;
      return r;
   endfunction

   function automatic void remember_key(input logic [KEY_BITS-1:0] k);
      key_pool.push_back(k);
      if (key_pool.size() > POOL_MAX) begin
         void'(key_pool.pop_front());
      end
   endfunction

   // mostly keys already inserted, some zero keys, extreme flavors and fresh keys
   function automatic req_type random_request();
      int                  sel;
      int                  f;
      mode_type            m;
      logic [KEY_BITS-1:0] k;
      m = mode_type'($urandom_range(0, 3));
      sel = $urandom_range(0, 99);
      k = '0;
      if (sel < 55 && key_pool.size() > 0) begin
         k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end else if (sel < 60) begin
         k = '0;
      end else if (sel < 70) begin
         for (f = 0; f < 5; f++) begin
            case ($urandom_range(0, 2))
               0: begin
                  k[f*FLAVOR_BITS +: FLAVOR_BITS] = '0;
               end
               1: begin
                  k[f*FLAVOR_BITS +: FLAVOR_BITS] = '1;
               end
               default: begin
                  k[f*FLAVOR_BITS +: FLAVOR_BITS] = FLAVOR_BITS'($urandom());
               end
            endcase
         end
      end else begin
         k = KEY_BITS'($urandom());
      end
      if (m == MODE_INSERT && k != '0) begin
         remember_key(k);
      end
      return build_req(m, k, INDEX_BITS'($urandom()));
   endfunction

   // drive one request, wait for its transfer, then record what it should return
   task automatic issue_request(input req_type r, input logic typed, input rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = table_update(r);
      expected_results.push_back(typed ? want : predicted);
   endtask

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%t %s: expected found=%0d closed=%0d index=%h status=%0d,",
                  $time, what, want.found, want.was_closed, want.stored_index, want.status,
                  " got found=%0d closed=%0d index=%h status=%0d",
                  got.found, got.was_closed, got.stored_index, got.status);
      end
   endtask

   // response side: check each transfer, then stall a random number of cycles
   always @(posedge clock) begin
      rsp_type want;
      int      stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            note_mismatch("unexpected result", '0, rsp_data);
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.found !== want.found || rsp_data.was_closed !== want.was_closed ||
                rsp_data.stored_index !== want.stored_index ||
                rsp_data.status !== want.status) begin
               note_mismatch("result mismatch", want, rsp_data);
            end
         end
         stall = no_idle ? 0 : $urandom_range(0, 6);
         rsp_ready <= (stall == 0);
         rsp_stall <= stall;
      end else if (rsp_stall > 1) begin
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_stall <= 0;
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles with no transfer on either channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      int i;
      for (i = 0; i < TABLE_DEPTH; i++) begin
         shadow_keys[i] = '0;
         shadow_closed[i] = 1'b0;
      end
      shadow_fill = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (i = 0; i < DIRECTED_COUNT; i++) begin
         issue_request(build_req(directed_steps[i].mode, directed_steps[i].key,
                                 directed_steps[i].index),
                       directed_steps[i].typed, directed_steps[i].want);
      end
      remember_key(KEY_LOW);
      remember_key(KEY_HIGH);
      remember_key(KEY_ONES);
      remember_key(KEY_TOP);

      // random traffic, every fourth block of 100 without idling
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         no_idle = ((i / 100) % 4 == 3);
         issue_request(random_request(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
